### sv/lif_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types, register indexes, reset values and a saturation helper for
// the leaky integrate-and-fire neuron update pipeline.
// ----------------------------------------------------------------------------
package lif_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IDX_V_THRESHOLD      = 3'd0;
  localparam logic [2:0] CFG_IDX_V_RESET_LEVEL    = 3'd1;
  localparam logic [2:0] CFG_IDX_EXC_DECAY        = 3'd2;
  localparam logic [2:0] CFG_IDX_INH_DECAY        = 3'd3;
  localparam logic [2:0] CFG_IDX_LEAK_GAIN        = 3'd4;
  localparam logic [2:0] CFG_IDX_CURRENT_GAIN     = 3'd5;
  localparam logic [2:0] CFG_IDX_BIAS_DRIVE       = 3'd6;
  localparam logic [2:0] CFG_IDX_REFRACTORY_TICKS = 3'd7;

  // Register values after reset.
  localparam logic [31:0] RST_V_THRESHOLD      = 32'hFFC9_0000;
  localparam logic [31:0] RST_V_RESET_LEVEL    = 32'hFFBA_0000;
  localparam logic [16:0] RST_EXC_DECAY        = 17'd62339;
  localparam logic [16:0] RST_INH_DECAY        = 17'd62339;
  localparam logic [16:0] RST_LEAK_GAIN        = 17'd655;
  localparam logic [31:0] RST_CURRENT_GAIN     = 32'd6711;
  localparam logic [31:0] RST_BIAS_DRIVE       = 32'hFFFF_4CCD;
  localparam logic [15:0] RST_REFRACTORY_TICKS = 16'd20;

  // Width of the voltage accumulator ahead of saturation.
  localparam int SUM_W = 43;

  // Live configuration as seen by the datapath.
  typedef struct packed {
    logic [31:0] v_threshold;
    logic [31:0] v_reset_level;
    logic [16:0] exc_decay;
    logic [16:0] inh_decay;
    logic [16:0] leak_gain;
    logic [31:0] current_gain;
    logic [31:0] bias_drive;
    logic [15:0] refractory_ticks;
  } lif_cfg_t;

  // Hand-off from the synapse decay stages to the membrane stages.
  typedef struct packed {
    logic        valid;
    logic [31:0] v;
    logic [31:0] exc;
    logic [31:0] inh;
    logic [33:0] leak;
    logic [15:0] refr;
  } lif_syn_t;

  // Clamp a wide signed value into signed 32 bits.
  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] x);
    logic [31:0] res;
    if ((x[SUM_W-1:31] == '0) || (x[SUM_W-1:31] == '1)) begin
      res = x[31:0];
    end else if (x[SUM_W-1]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### sv/lif_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_cfg_regs
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module lif_cfg_regs
  import lif_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output lif_cfg_t         cfg
);

  lif_cfg_t cfg_r;
  lif_cfg_t cfg_nxt;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_V_THRESHOLD:      cfg_nxt.v_threshold      = cfg_wdata;
        CFG_IDX_V_RESET_LEVEL:    cfg_nxt.v_reset_level    = cfg_wdata;
        CFG_IDX_EXC_DECAY:        cfg_nxt.exc_decay        = cfg_wdata[16:0];
        CFG_IDX_INH_DECAY:        cfg_nxt.inh_decay        = cfg_wdata[16:0];
        CFG_IDX_LEAK_GAIN:        cfg_nxt.leak_gain        = cfg_wdata[16:0];
        CFG_IDX_CURRENT_GAIN:     cfg_nxt.current_gain     = cfg_wdata;
        CFG_IDX_BIAS_DRIVE:       cfg_nxt.bias_drive       = cfg_wdata;
        CFG_IDX_REFRACTORY_TICKS: cfg_nxt.refractory_ticks = cfg_wdata[15:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.v_threshold      <= RST_V_THRESHOLD;
      cfg_r.v_reset_level    <= RST_V_RESET_LEVEL;
      cfg_r.exc_decay        <= RST_EXC_DECAY;
      cfg_r.inh_decay        <= RST_INH_DECAY;
      cfg_r.leak_gain        <= RST_LEAK_GAIN;
      cfg_r.current_gain     <= RST_CURRENT_GAIN;
      cfg_r.bias_drive       <= RST_BIAS_DRIVE;
      cfg_r.refractory_ticks <= RST_REFRACTORY_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### sv/lif_syn_decay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_syn_decay
// Pipeline stages one and two: decay products for both synaptic currents
// and the leak product, then rounding and saturation.
// ----------------------------------------------------------------------------
module lif_syn_decay
  import lif_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [31:0] in_membrane_v,
  input  wire logic [31:0] in_exc_current,
  input  wire logic [31:0] in_inh_current,
  input  wire logic [15:0] in_refractory_left,
  input  wire lif_cfg_t    cfg,
  output lif_syn_t         syn
);

  // Stage one registers.
  logic               s1_valid_r;
  logic [31:0]        s1_v_r;
  logic [15:0]        s1_refr_r;
  logic signed [49:0] s1_p_exc_r;
  logic signed [49:0] s1_p_inh_r;
  logic signed [49:0] s1_p_leak_r;
  logic signed [49:0] p_exc_nxt;
  logic signed [49:0] p_inh_nxt;
  logic signed [49:0] p_leak_nxt;

  // Stage two logic.
  logic signed [49:0] r_exc;
  logic signed [49:0] r_inh;
  logic signed [49:0] r_leak;
  logic signed [33:0] q_exc;
  logic signed [33:0] q_inh;
  lif_syn_t           s2_r;
  lif_syn_t           s2_nxt;

  // Signed current or voltage times unsigned Q1.16 factor.
  assign p_exc_nxt  = $signed(in_exc_current) * $signed({1'b0, cfg.exc_decay});
  assign p_inh_nxt  = $signed(in_inh_current) * $signed({1'b0, cfg.inh_decay});
  assign p_leak_nxt = $signed(in_membrane_v) * $signed({1'b0, cfg.leak_gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_v_r      <= in_membrane_v;
    s1_refr_r   <= in_refractory_left;
    s1_p_exc_r  <= p_exc_nxt;
    s1_p_inh_r  <= p_inh_nxt;
    s1_p_leak_r <= p_leak_nxt;
  end

  // Round half up at bit 16, then drop the fraction.
  assign r_exc  = s1_p_exc_r + 50'sd32768;
  assign r_inh  = s1_p_inh_r + 50'sd32768;
  assign r_leak = s1_p_leak_r + 50'sd32768;
  assign q_exc  = r_exc[49:16];
  assign q_inh  = r_inh[49:16];

  always_comb begin
    s2_nxt.valid = s1_valid_r;
    s2_nxt.v     = s1_v_r;
    s2_nxt.refr  = s1_refr_r;
    s2_nxt.exc   = sat32(SUM_W'(q_exc));
    s2_nxt.inh   = sat32(SUM_W'(q_inh));
    s2_nxt.leak  = r_leak[49:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.v    <= s2_nxt.v;
    s2_r.exc  <= s2_nxt.exc;
    s2_r.inh  <= s2_nxt.inh;
    s2_r.leak <= s2_nxt.leak;
    s2_r.refr <= s2_nxt.refr;
  end

  assign syn = s2_r;

endmodule
`default_nettype wire

### sv/lif_membrane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_membrane
// Pipeline stages three to six: net synaptic current, drive product,
// voltage sum, then saturation, threshold test and output registers.
// ----------------------------------------------------------------------------
module lif_membrane
  import lif_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire lif_syn_t    syn,
  input  wire lif_cfg_t    cfg,
  output logic             out_valid,
  output logic [31:0]      out_next_v,
  output logic [31:0]      out_next_exc,
  output logic [31:0]      out_next_inh,
  output logic [15:0]      out_next_refractory,
  output logic             out_spike
);

  // Stage three: net current.
  logic        s3_valid_r;
  logic [31:0] s3_v_r;
  logic [31:0] s3_exc_r;
  logic [31:0] s3_inh_r;
  logic [33:0] s3_leak_r;
  logic [15:0] s3_refr_r;
  logic [31:0] s3_net_r;
  logic [31:0] net_nxt;

  // Stage four: drive product.
  logic               s4_valid_r;
  logic [31:0]        s4_v_r;
  logic [31:0]        s4_exc_r;
  logic [31:0]        s4_inh_r;
  logic [33:0]        s4_leak_r;
  logic [15:0]        s4_refr_r;
  logic signed [64:0] s4_prod_r;
  logic signed [64:0] prod_nxt;

  // Stage five: voltage sum.
  logic                   s5_valid_r;
  logic [31:0]            s5_exc_r;
  logic [31:0]            s5_inh_r;
  logic [15:0]            s5_refr_r;
  logic signed [SUM_W-1:0] s5_sum_r;
  logic signed [64:0]     r_prod;
  logic signed [40:0]     drive;
  logic signed [SUM_W-1:0] sum_nxt;

  // Stage six: output registers.
  logic        out_valid_r;
  logic [31:0] out_v_r;
  logic [31:0] out_exc_r;
  logic [31:0] out_inh_r;
  logic [15:0] out_refr_r;
  logic        out_spike_r;
  logic [31:0] v_sat;
  logic        fire;
  logic [31:0] v_nxt;
  logic [15:0] refr_nxt;

  assign net_nxt = sat32(SUM_W'($signed(syn.exc)) - SUM_W'($signed(syn.inh)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= syn.valid;
    end
    s3_v_r    <= syn.v;
    s3_exc_r  <= syn.exc;
    s3_inh_r  <= syn.inh;
    s3_leak_r <= syn.leak;
    s3_refr_r <= syn.refr;
    s3_net_r  <= net_nxt;
  end

  // Signed net current times unsigned Q8.24 gain.
  assign prod_nxt = $signed(s3_net_r) * $signed({1'b0, cfg.current_gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_v_r    <= s3_v_r;
    s4_exc_r  <= s3_exc_r;
    s4_inh_r  <= s3_inh_r;
    s4_leak_r <= s3_leak_r;
    s4_refr_r <= s3_refr_r;
    s4_prod_r <= prod_nxt;
  end

  // Round the drive at bit 24 and form the unsaturated new voltage.
  assign r_prod  = s4_prod_r + 65'sd8388608;
  assign drive   = r_prod[64:24];
  assign sum_nxt = SUM_W'($signed(s4_v_r)) - SUM_W'($signed(s4_leak_r))
                 + SUM_W'(drive) + SUM_W'($signed(cfg.bias_drive));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
    s5_exc_r  <= s4_exc_r;
    s5_inh_r  <= s4_inh_r;
    s5_refr_r <= s4_refr_r;
    s5_sum_r  <= sum_nxt;
  end

  // Refractory hold, threshold test and reset.
  assign v_sat = sat32(s5_sum_r);

  always_comb begin
    fire     = 1'b0;
    v_nxt    = v_sat;
    refr_nxt = '0;
    if (s5_refr_r != '0) begin
      v_nxt    = cfg.v_reset_level;
      refr_nxt = s5_refr_r - 16'd1;
    end else if ($signed(v_sat) >= $signed(cfg.v_threshold)) begin
      fire     = 1'b1;
      v_nxt    = cfg.v_reset_level;
      refr_nxt = cfg.refractory_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_spike_r <= 1'b0;
    end else begin
      out_valid_r <= s5_valid_r;
      out_spike_r <= s5_valid_r & fire;
    end
    out_v_r    <= v_nxt;
    out_exc_r  <= s5_exc_r;
    out_inh_r  <= s5_inh_r;
    out_refr_r <= refr_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_next_v          = out_v_r;
  assign out_next_exc        = out_exc_r;
  assign out_next_inh        = out_inh_r;
  assign out_next_refractory = out_refr_r;
  assign out_spike           = out_spike_r;

`ifndef NO_ASSERTIONS
  // A spike is only reported with a valid result.
  a_spike_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_spike_r |-> out_valid_r)
    else $error("spike without a valid result");

  // A spike reloads the refractory count from the register.
  a_spike_refr: assert property (@(posedge clk) disable iff (!rst_n)
    out_spike_r |-> (out_refr_r == $past(cfg.refractory_ticks)))
    else $error("spike did not reload the refractory count");

  // A spike puts the voltage at the reset level.
  a_spike_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_spike_r |-> (out_v_r == $past(cfg.v_reset_level)))
    else $error("spike did not reset the voltage");

  // A non-zero count without a spike comes from the refractory hold.
  a_refr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_spike_r && (out_refr_r != '0))
      |-> (out_v_r == $past(cfg.v_reset_level)))
    else $error("refractory voltage not held at reset level");
`endif

endmodule
`default_nettype wire

### sv/lif_neuron_exp_synapse_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_neuron_exp_synapse_step
// One forward-Euler step of a leaky integrate-and-fire neuron with
// exponentially decaying excitatory and inhibitory synaptic currents.
// ----------------------------------------------------------------------------
// The block takes one neuron state in every clock cycle and returns its
// updated state, marked by a one-cycle out_valid strobe; results follow in
// the same order as the inputs, one per cycle. The datapath has six register
// stages: decay and leak products, their rounding, the net current, the drive
// product, the voltage sum and the threshold test with the output registers.
// busy is high only during reset. Configuration registers are read live by
// the pipeline, so they should be written only when no transaction is in
// flight.
// ----------------------------------------------------------------------------
module lif_neuron_exp_synapse_step
  import lif_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // Input channel.
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_membrane_v,
  input  wire logic [31:0] in_exc_current,
  input  wire logic [31:0] in_inh_current,
  input  wire logic [15:0] in_refractory_left,
  // Result channel.
  output logic             out_valid,
  output logic [31:0]      out_next_v,
  output logic [31:0]      out_next_exc,
  output logic [31:0]      out_next_inh,
  output logic [15:0]      out_next_refractory,
  output logic             out_spike
);

  lif_cfg_t cfg;
  lif_syn_t syn;
  logic     in_fire;

  // The pipeline never stalls, so only reset holds off new transactions.
  assign busy    = ~rst_n;
  assign in_fire = start & ~busy;

  lif_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lif_syn_decay u_decay (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_fire),
    .in_membrane_v      (in_membrane_v),
    .in_exc_current     (in_exc_current),
    .in_inh_current     (in_inh_current),
    .in_refractory_left (in_refractory_left),
    .cfg                (cfg),
    .syn                (syn)
  );

  lif_membrane u_membrane (
    .clk                 (clk),
    .rst_n               (rst_n),
    .syn                 (syn),
    .cfg                 (cfg),
    .out_valid           (out_valid),
    .out_next_v          (out_next_v),
    .out_next_exc        (out_next_exc),
    .out_next_inh        (out_next_inh),
    .out_next_refractory (out_next_refractory),
    .out_spike           (out_spike)
  );

endmodule
`default_nettype wire
